@@ sv/bcs_pkg.sv @@
// shared constants, types and helper functions of the bcch block scheduler
package bcs_pkg;

	// multiframe geometry
	localparam int unsigned MFRAME_LEN       = 51;
	localparam int unsigned TC_COUNT         = 8;
	localparam int unsigned NORMAL_START_POS = 1;
	localparam int unsigned EXT_START_POS    = 5;
	localparam int unsigned EXT_TARGET_POS   = 4;
	localparam int unsigned EXT_WRAP         = 55;

	// field widths
	localparam int unsigned FN_W   = 22;
	localparam int unsigned MASK_W = 8;
	localparam int unsigned GAP_W  = 9;
	localparam int unsigned POS_W  = 6;
	localparam int unsigned TC_W   = $clog2(TC_COUNT);

	// frame / 51 as (frame * DIV_RECIP) >> DIV_SHIFT, exact for any 22-bit frame
	localparam int unsigned DIV_SHIFT  = 28;
	localparam int unsigned DIV_RECIP  = (2 ** DIV_SHIFT + MFRAME_LEN - 1) / MFRAME_LEN;
	localparam int unsigned RECIP_W    = 23;
	localparam int unsigned PROD_W     = FN_W + RECIP_W;
	localparam int unsigned QUO_W      = 17;

	// configuration register indexes
	typedef enum logic {
		REG_NORMAL_MASK   = 1'b0,
		REG_EXTENDED_MASK = 1'b1
	} reg_idx_t;

	// multiframe position and tc of one frame
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [TC_W-1:0]  tc;
	} pos_tc_t;

	// per-frame search results ahead of the gap arithmetic
	typedef struct packed {
		logic             start;
		logic             kind;
		logic             have_n;
		logic [POS_W-1:0] base_n;
		logic [TC_W-1:0]  dist_n;
		logic             have_e;
		logic [POS_W-1:0] base_e;
		logic [TC_W-1:0]  dist_e;
	} search_t;

	// multiframes from tc to the first tc whose mask bit is set (0 for an empty mask)
	function automatic logic [TC_W-1:0] tc_distance(input logic [TC_W-1:0] tc,
			input logic [MASK_W-1:0] mask);
		logic [2*MASK_W-1:0] dbl;
		logic [MASK_W-1:0]   rot;
		logic [TC_W-1:0]     d;
		dbl = {mask, mask};
		rot = dbl[tc +: MASK_W];
		d   = '0;
		for (int j = MASK_W - 1; j >= 0; j--) begin
			if (rot[j]) begin
				d = TC_W'(j);
			end
		end
		return d;
	endfunction

endpackage

@@ sv/bcs_divmod.sv @@
// two pipeline stages splitting the frame number into multiframe position and tc
module bcs_divmod import bcs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [FN_W-1:0] frame_number,
	output logic            up_ready,
	output logic            valid_s2,
	output pos_tc_t         pos_tc_s2,
	input  logic            dn_ready
);

	logic              valid_s1;
	logic [FN_W-1:0]   fn_s1;
	logic [QUO_W-1:0]  quo_s1;
	logic              rdy_s1;
	logic              rdy_s2;
	logic [PROD_W-1:0] prod;
	logic [FN_W-1:0]   quo_x51;
	logic [FN_W-1:0]   rem;

	// stage ready: a stage takes a new word when empty or when it moves on
	assign rdy_s2   = !valid_s2 || dn_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// reciprocal multiply for the quotient by 51
	assign prod = PROD_W'(frame_number) * PROD_W'(DIV_RECIP);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			fn_s1  <= frame_number;
			quo_s1 <= prod[DIV_SHIFT +: QUO_W];
		end
	end

	// remainder by back-multiplication, product kept at full frame width
	assign quo_x51 = FN_W'(quo_s1) * FN_W'(MFRAME_LEN);
	assign rem     = fn_s1 - quo_x51;

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			pos_tc_s2.pos <= rem[POS_W-1:0];
			pos_tc_s2.tc  <= quo_s1[TC_W-1:0];
		end
	end

endmodule

@@ sv/bcs_search.sv @@
// occasion search stage and gap selection stage feeding the output word
module bcs_search import bcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  pos_tc_t           pos_tc_s2,
	output logic              up_ready,
	input  logic [MASK_W-1:0] normal_mask,
	input  logic [MASK_W-1:0] extended_mask,
	output logic              valid_s4,
	output logic              start_s4,
	output logic              kind_s4,
	output logic [GAP_W-1:0]  gap_s4,
	output logic              gap_valid_s4,
	input  logic              dn_ready
);

	logic              valid_s3;
	search_t           srch_s3;
	search_t           srch;
	logic              rdy_s3;
	logic              rdy_s4;
	logic [TC_W-1:0]   tcbit_idx;
	logic [TC_W-1:0]   tc_n;
	logic [TC_W-1:0]   tc_e;
	logic [GAP_W-1:0]  gap_n;
	logic [GAP_W-1:0]  gap_e;
	logic [GAP_W-1:0]  gap_sel;

	assign rdy_s4   = !valid_s4 || dn_ready;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign up_ready = rdy_s3;
	assign tcbit_idx = pos_tc_s2.tc;

	// block start decision and per-kind base offset and tc distance
	always_comb begin
		srch = '0;
		if (pos_tc_s2.pos == POS_W'(NORMAL_START_POS) && normal_mask[tcbit_idx]) begin
			srch.start = 1'b1;
			srch.kind  = 1'b0;
		end else if (pos_tc_s2.pos == POS_W'(EXT_START_POS) && extended_mask[tcbit_idx]) begin
			srch.start = 1'b1;
			srch.kind  = 1'b1;
		end
		// normal occasion targets position 0
		if (pos_tc_s2.pos != '0) begin
			srch.base_n = POS_W'(MFRAME_LEN) - pos_tc_s2.pos;
			tc_n        = pos_tc_s2.tc + TC_W'(1);
		end else begin
			srch.base_n = '0;
			tc_n        = pos_tc_s2.tc;
		end
		// extended occasion targets position 4
		if (pos_tc_s2.pos <= POS_W'(EXT_TARGET_POS)) begin
			srch.base_e = POS_W'(EXT_TARGET_POS) - pos_tc_s2.pos;
			tc_e        = pos_tc_s2.tc;
		end else begin
			srch.base_e = POS_W'(EXT_WRAP) - pos_tc_s2.pos;
			tc_e        = pos_tc_s2.tc + TC_W'(1);
		end
		srch.have_n = normal_mask != '0;
		srch.have_e = extended_mask != '0;
		srch.dist_n = tc_distance(tc_n, normal_mask);
		srch.dist_e = tc_distance(tc_e, extended_mask);
	end

	// stage 3 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	// stage 3 payload
	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			srch_s3 <= srch;
		end
	end

	// gaps in frames and the nearer of the two
	assign gap_n = GAP_W'(srch_s3.base_n) + GAP_W'(srch_s3.dist_n) * GAP_W'(MFRAME_LEN);
	assign gap_e = GAP_W'(srch_s3.base_e) + GAP_W'(srch_s3.dist_e) * GAP_W'(MFRAME_LEN);

	always_comb begin
		gap_sel = '0;
		if (srch_s3.have_n) begin
			gap_sel = gap_n;
		end
		if (srch_s3.have_e && (!srch_s3.have_n || gap_e < gap_n)) begin
			gap_sel = gap_e;
		end
	end

	// stage 4 valid, the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (rdy_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	// stage 4 payload
	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			start_s4     <= srch_s3.start;
			kind_s4      <= srch_s3.kind;
			gap_s4       <= gap_sel;
			gap_valid_s4 <= srch_s3.have_n || srch_s3.have_e;
		end
	end

endmodule

@@ sv/bcch_block_scheduler_unit.sv @@
// top level of the bcch block scheduler: register port, pipeline and output word
// Each frame number word yields one result word at the outputs, and a new word can be
// accepted in every cycle while no stall comes back from the output side; the word
// passes through four pipeline stages (reciprocal multiply, remainder, occasion
// search, gap add and compare). Stall from the output side backs up through the stages
// without losing or repeating a word. The two tc masks are written over the APB
// port at byte addresses 0 (normal, reset 0xff) and 4 (extended, reset 0x00)
// and must only be written while no word is in flight.
module bcch_block_scheduler_unit import bcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// input channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [FN_W-1:0]  frame_number,
	// output channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic             block_start,
	output logic             block_kind,
	output logic [GAP_W-1:0] gap_frames,
	output logic             gap_valid,
	// register port
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [MASK_W-1:0] normal_mask_q;
	logic [MASK_W-1:0] extended_mask_q;
	logic              wr_en;
	reg_idx_t          reg_idx;
	logic              dm_ready;
	logic              sr_ready;
	logic              valid_s2;
	pos_tc_t           pos_tc_s2;

	// register write and read
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_mask_q   <= '1;
			extended_mask_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_NORMAL_MASK:   normal_mask_q   <= pwdata[MASK_W-1:0];
				REG_EXTENDED_MASK: extended_mask_q <= pwdata[MASK_W-1:0];
				default:           normal_mask_q   <= normal_mask_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NORMAL_MASK:   prdata = 32'(normal_mask_q);
			REG_EXTENDED_MASK: prdata = 32'(extended_mask_q);
			default:           prdata = '0;
		endcase
	end

	// position and tc stages
	bcs_divmod u_divmod (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.frame_number (frame_number),
		.up_ready     (dm_ready),
		.valid_s2     (valid_s2),
		.pos_tc_s2    (pos_tc_s2),
		.dn_ready     (sr_ready)
	);

	assign in_stall = !dm_ready;

	// search and gap stages
	bcs_search u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s2      (valid_s2),
		.pos_tc_s2     (pos_tc_s2),
		.up_ready      (sr_ready),
		.normal_mask   (normal_mask_q),
		.extended_mask (extended_mask_q),
		.valid_s4      (out_valid),
		.start_s4      (block_start),
		.kind_s4       (block_kind),
		.gap_s4        (gap_frames),
		.gap_valid_s4  (gap_valid),
		.dn_ready      (!out_stall)
	);

	// extended kind only comes with a block start
	a_kind_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_kind |-> block_start)
		else $error("block_kind set without block_start");

	// no occasion means a zero gap
	a_gap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !gap_valid |-> gap_frames == '0)
		else $error("gap_frames nonzero without gap_valid");

	// gap never exceeds eight multiframes
	a_gap_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gap_frames <= GAP_W'(TC_COUNT * MFRAME_LEN - 1))
		else $error("gap_frames out of range");

	// remainder stage stays inside the multiframe
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> pos_tc_s2.pos < POS_W'(MFRAME_LEN))
		else $error("multiframe position out of range");

endmodule
